// ----- hdl/dshot_erpm_telemetry_codec_unit_defines.svh -----
// Assertion macros used by the telemetry codec top level.
// Each macro expects clk and arst_n in scope; no other dependencies.
`ifndef DSHOT_ERPM_TELEMETRY_CODEC_UNIT_DEFINES_SVH
`define DSHOT_ERPM_TELEMETRY_CODEC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DETC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DETC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/detc_pkg.sv -----
// Shared constants and functions of the telemetry codec: GCR tables, CRC4
// and period unpacking. No dependencies.
`timescale 1ns / 1ps

package detc_pkg;

	localparam int FrameW  = 20;
	localparam int RxW     = 21;
	localparam int PacketW = 16;
	localparam int PeriodW = 32;
	localparam int PerOutW = 16;

	localparam logic [31:0] GcrValidMask = 32'h6EEC_EE00;
	localparam logic [8:0]  MantMax      = 9'd511;
	localparam logic [2:0]  ExpoMax      = 3'd7;

	// Nibble to 5-bit GCR code.
	function automatic logic [4:0] gcr_of_nibble(input logic [3:0] nib);
		logic [4:0] code;
		case (nib)
			4'h0: code = 5'h19;
			4'h1: code = 5'h1B;
			4'h2: code = 5'h12;
			4'h3: code = 5'h13;
			4'h4: code = 5'h1D;
			4'h5: code = 5'h15;
			4'h6: code = 5'h16;
			4'h7: code = 5'h17;
			4'h8: code = 5'h1A;
			4'h9: code = 5'h09;
			4'hA: code = 5'h0A;
			4'hB: code = 5'h0B;
			4'hC: code = 5'h1E;
			4'hD: code = 5'h0D;
			4'hE: code = 5'h0E;
			default: code = 5'h0F;
		endcase
		return code;
	endfunction

	// GCR code to nibble; codes outside the valid set return zero.
	function automatic logic [3:0] nibble_of_gcr(input logic [4:0] code);
		logic [3:0] nib;
		case (code)
			5'h09: nib = 4'h9;
			5'h0A: nib = 4'hA;
			5'h0B: nib = 4'hB;
			5'h0D: nib = 4'hD;
			5'h0E: nib = 4'hE;
			5'h0F: nib = 4'hF;
			5'h12: nib = 4'h2;
			5'h13: nib = 4'h3;
			5'h15: nib = 4'h5;
			5'h16: nib = 4'h6;
			5'h17: nib = 4'h7;
			5'h1A: nib = 4'h8;
			5'h1B: nib = 4'h1;
			5'h1D: nib = 4'h4;
			5'h1E: nib = 4'hC;
			default: nib = 4'h0;
		endcase
		return nib;
	endfunction

	// Inverted XOR of the three upper nibbles.
	function automatic logic [3:0] crc4(input logic [11:0] v);
		return ~(v[3:0] ^ v[7:4] ^ v[11:8]);
	endfunction

	function automatic logic [PerOutW-1:0] period_of(input logic [PacketW-1:0] pkt);
		logic [PerOutW-1:0] mant;
		mant = {7'd0, pkt[12:4]};
		return mant << pkt[15:13];
	endfunction

	typedef struct packed {
		logic [FrameW-1:0]  tx_frame;
		logic [PacketW-1:0] packet;
		logic [PerOutW-1:0] period_out;
		logic               crc_ok;
	} result_t;

endpackage

// ----- hdl/detc_decoder.sv -----
// Receive path: undoes the line prefix XOR and maps GCR groups to nibbles.
// Depends on detc_pkg.
`timescale 1ns / 1ps

module detc_decoder (
	input  logic [detc_pkg::RxW-1:0]     rx_frame,
	output logic [detc_pkg::PacketW-1:0] packet
);
	import detc_pkg::*;

	logic [FrameW-1:0]  gcr;
	logic [PacketW-1:0] nibbles;
	logic [3:0]         group_ok;

	assign gcr = rx_frame[FrameW-1:0] ^ rx_frame[FrameW:1];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			nibbles[4*i +: 4] = nibble_of_gcr(gcr[5*i +: 5]);
			group_ok[i]       = GcrValidMask[gcr[5*i +: 5]];
		end
	end

	// A single bad group discards the whole packet.
	assign packet = (&group_ok) ? nibbles : '0;

endmodule

// ----- hdl/detc_encoder.sv -----
// Transmit path: packs a period into exponent, mantissa and CRC4, then
// GCR-encodes and prefix-XORs into the line frame. Depends on detc_pkg.
`timescale 1ns / 1ps

module detc_encoder (
	input  logic [detc_pkg::PeriodW-1:0] period_us,
	output logic [detc_pkg::PacketW-1:0] packet,
	output logic [detc_pkg::FrameW-1:0]  tx_frame
);
	import detc_pkg::*;

	logic [2:0]        expo;
	logic [8:0]        shifted;
	logic [FrameW-1:0] gcr;

	// Exponent is the bit length of period[15:9].
	always_comb begin
		expo = '0;
		for (int b = 0; b < 7; b++) begin
			if (period_us[9+b]) expo = 3'(b + 1);
		end
	end

	assign shifted = 9'(period_us[15:0] >> expo);

	always_comb begin
		if (|period_us[PeriodW-1:16]) begin
			packet[15:13] = ExpoMax;
			packet[12:4]  = MantMax;
		end else begin
			packet[15:13] = expo;
			packet[12:4]  = shifted;
		end
		packet[3:0] = crc4(packet[15:4]);
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			gcr[5*i +: 5] = gcr_of_nibble(packet[4*i +: 4]);
		end
	end

	// Each line bit is the XOR of its GCR bit and every bit above it.
	always_comb begin
		for (int i = 0; i < FrameW; i++) begin
			tx_frame[i] = ^(gcr >> i);
		end
	end

endmodule

// ----- hdl/dshot_erpm_telemetry_codec_unit.sv -----
// Top level of the telemetry codec: input register, decode and encode
// paths, result register. Depends on detc_pkg, detc_decoder, detc_encoder.
//
// Usage:
//   The input channel (in_valid/in_ready) carries func, rx_frame and
//   period_us. func low decodes rx_frame into packet, period_out and
//   crc_ok, echoing rx_frame[19:0] on tx_frame. func high encodes
//   period_us into a packet and a 20-bit tx_frame.
//   The output channel (out_valid/out_ready) carries one result per item.
//   Path: an accepted item is held in the input register, then in the
//   result register, which drives the output channel.
//   Throughput: one item per cycle while out_ready stays high, set by the
//   single-pass logic between the input register and the result register.
//   Stall: when out_ready is low the result register holds; the input
//   register still takes one more item, and in_ready drops only while
//   both registers are full and the receiver stalls.
//   Reset: arst_n clears both valid flags; no item is in flight after it.
`timescale 1ns / 1ps

`include "dshot_erpm_telemetry_codec_unit_defines.svh"

module dshot_erpm_telemetry_codec_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [detc_pkg::RxW-1:0]      rx_frame,
	input  logic [detc_pkg::PeriodW-1:0]  period_us,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [detc_pkg::FrameW-1:0]   tx_frame,
	output logic [detc_pkg::PacketW-1:0]  packet,
	output logic [detc_pkg::PerOutW-1:0]  period_out,
	output logic                          crc_ok
);
	import detc_pkg::*;

	logic               valid_s1;
	logic               func_s1;
	logic [RxW-1:0]     rx_frame_s1;
	logic [PeriodW-1:0] period_us_s1;
	logic               valid_s2;
	result_t            result_s2;

	logic               adv1;
	logic               adv2;
	logic [PacketW-1:0] dec_packet;
	logic [PacketW-1:0] enc_packet;
	logic [FrameW-1:0]  enc_frame;
	logic [PacketW-1:0] sel_packet;
	result_t            result_d;

	assign adv2     = !valid_s2 || out_ready;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			func_s1      <= func;
			rx_frame_s1  <= rx_frame;
			period_us_s1 <= period_us;
		end
	end

	detc_decoder u_decoder (
		.rx_frame (rx_frame_s1),
		.packet   (dec_packet)
	);

	detc_encoder u_encoder (
		.period_us (period_us_s1),
		.packet    (enc_packet),
		.tx_frame  (enc_frame)
	);

	always_comb begin
		sel_packet          = func_s1 ? enc_packet : dec_packet;
		result_d.tx_frame   = func_s1 ? enc_frame : rx_frame_s1[FrameW-1:0];
		result_d.packet     = sel_packet;
		result_d.period_out = period_of(sel_packet);
		result_d.crc_ok     = (crc4(sel_packet[15:4]) == sel_packet[3:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid  = valid_s2;
	assign tx_frame   = result_s2.tx_frame;
	assign packet     = result_s2.packet;
	assign period_out = result_s2.period_out;
	assign crc_ok     = result_s2.crc_ok;

	`DETC_ASSERT_NEXT(a_s1_moves_to_s2, valid_s1 && adv2, out_valid,
		"staged item did not reach the result register")
	`DETC_ASSERT_NEXT(a_s1_holds_on_stall, valid_s1 && !adv2, valid_s1,
		"staged item lost during a stall")
	`DETC_ASSERT_NOW(a_ready_low_only_when_full, !in_ready,
		valid_s1 && out_valid && !out_ready, "in_ready low with room to spare")
	`DETC_ASSERT_NOW(a_zero_packet_result, out_valid && packet == 16'd0,
		period_out == 16'd0 && !crc_ok, "zero packet with nonzero period or good CRC")

endmodule

// ----- tb/detc_tb_pkg.sv -----
// Shared verification items for the telemetry codec testbench: operation codes,
// the GCR code table, the CRC4 and the frame builder. Depends on nothing.
`timescale 1ns / 1ps

package detc_tb_pkg;

	typedef enum logic {
		FUNC_DECODE = 1'b0,
		FUNC_ENCODE = 1'b1
	} codec_op_e;

	// Five-bit line code of each nibble; nibble n sits at bits [5n+4:5n].
	localparam logic [79:0] GCR_TABLE = {
		5'h0F, 5'h0E, 5'h0D, 5'h1E, 5'h0B, 5'h0A, 5'h09, 5'h1A,
		5'h17, 5'h16, 5'h15, 5'h1D, 5'h13, 5'h12, 5'h1B, 5'h19
	};

	// Inverted XOR of the exponent/mantissa nibbles.
	function automatic logic [3:0] packet_crc(input logic [11:0] fields);
		logic [11:0] folded;
		folded = fields ^ (fields >> 4) ^ (fields >> 8);
		return ~folded[3:0];
	endfunction

	// GCR-encode a packet, then make every line bit the XOR of its code bit
	// and all code bits above it.
	function automatic logic [19:0] line_of_packet(input logic [15:0] pkt);
		logic [19:0] codes;
		logic [19:0] line;
		int grp;
		int nib;
		int b;
		for (grp = 0; grp < 4; grp++) begin
			nib = pkt[4*grp +: 4];
			codes[5*grp +: 5] = GCR_TABLE[5*nib +: 5];
		end
		line[19] = codes[19];
		for (b = 18; b >= 0; b--)
			line[b] = codes[b] ^ line[b+1];
		return line;
	endfunction

endpackage

// ----- tb/detc_checker.sv -----
// Checker of the telemetry codec: watches both channels, predicts each result
// from the accepted input and compares it. Depends on detc_pkg and detc_tb_pkg.
`timescale 1ns / 1ps

module detc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          func,
	input  logic [detc_pkg::RxW-1:0]      rx_frame,
	input  logic [detc_pkg::PeriodW-1:0]  period_us,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [detc_pkg::FrameW-1:0]   tx_frame,
	input  logic [detc_pkg::PacketW-1:0]  packet,
	input  logic [detc_pkg::PerOutW-1:0]  period_out,
	input  logic                          crc_ok,
	output int                            fail_count,
	output int                            awaited,
	output int                            checked_count,
	output int                            crc_bad_count
);

	import detc_pkg::*;
	import detc_tb_pkg::*;

	result_t awaited_results[$];

	function automatic result_t codec_result_of(input logic op, input logic [20:0] line,
			input logic [31:0] per);
		result_t r;
		logic [19:0] codes;
		logic [4:0] code;
		logic [15:0] pkt;
		logic [15:0] wide_mant;
		logic [31:0] hi;
		logic [2:0] expo;
		logic [8:0] mant;
		logic bad;
		int grp;
		int n;
		pkt = '0;
		if (op == FUNC_DECODE) begin
			codes = line[19:0] ^ line[20:1];
			bad = 1'b0;
			for (grp = 0; grp < 4; grp++) begin
				code = codes[5*grp +: 5];
				if (!GcrValidMask[code]) begin
					bad = 1'b1;
				end else begin
					for (n = 0; n < 16; n++)
						if (GCR_TABLE[5*n +: 5] == code)
							pkt[4*grp +: 4] = 4'(n);
				end
			end
			if (bad)
				pkt = '0;
			r.tx_frame = line[19:0];
		end else begin
			if (per >= 32'h0001_0000) begin
				expo = ExpoMax;
				mant = MantMax;
			end else begin
				// Exponent is the bit length of the part above the mantissa.
				hi = per >> 9;
				expo = 3'd0;
				for (n = 0; n < 7; n++) begin
					if (hi != 0) begin
						expo++;
						hi = hi >> 1;
					end
				end
				mant = 9'(per >> expo);
			end
			pkt = {expo, mant, 4'h0};
			pkt[3:0] = packet_crc(pkt[15:4]);
			r.tx_frame = line_of_packet(pkt);
		end
		r.packet = pkt;
		wide_mant = {7'd0, pkt[12:4]};
		r.period_out = wide_mant << pkt[15:13];
		r.crc_ok = (packet_crc(pkt[15:4]) == pkt[3:0]);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		awaited = 0;
		checked_count = 0;
		crc_bad_count = 0;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				awaited_results.push_back(codec_result_of(func, rx_frame, period_us));
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with nothing awaited: expected none, got packet %h",
						$time, packet);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("tx_frame", 32'(want.tx_frame), 32'(tx_frame));
					check_field("packet", 32'(want.packet), 32'(packet));
					check_field("period_out", 32'(want.period_out), 32'(period_out));
					check_field("crc_ok", 32'(want.crc_ok), 32'(crc_ok));
					checked_count++;
					if (!want.crc_ok)
						crc_bad_count++;
				end
			end
			awaited = awaited_results.size();
		end
	end

endmodule

// ----- tb/dshot_erpm_telemetry_codec_unit_tb.sv -----
// Testbench top of the telemetry codec: clock, reset, stimulus in four handshake
// phases and the verdict. Depends on detc_pkg, detc_tb_pkg and detc_checker.
`timescale 1ns / 1ps

module dshot_erpm_telemetry_codec_unit_tb;

	import detc_pkg::*;
	import detc_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic func;
	logic [RxW-1:0] rx_frame;
	logic [PeriodW-1:0] period_us;
	logic out_valid;
	logic out_ready;
	logic [FrameW-1:0] tx_frame;
	logic [PacketW-1:0] packet;
	logic [PerOutW-1:0] period_out;
	logic crc_ok;

	int fails;
	int awaited;
	int checked;
	int crc_bad;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int decode_sent = 0;
	int encode_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dshot_erpm_telemetry_codec_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.rx_frame   (rx_frame),
		.period_us  (period_us),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tx_frame   (tx_frame),
		.packet     (packet),
		.period_out (period_out),
		.crc_ok     (crc_ok)
	);

	detc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.rx_frame      (rx_frame),
		.period_us     (period_us),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_frame      (tx_frame),
		.packet        (packet),
		.period_out    (period_out),
		.crc_ok        (crc_ok),
		.fail_count    (fails),
		.awaited       (awaited),
		.checked_count (checked),
		.crc_bad_count (crc_bad)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Called at a clock edge; returns at the edge where the transfer happens.
	task automatic send_item(input codec_op_e op, input logic [20:0] line,
			input logic [31:0] per);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		rx_frame <= line;
		period_us <= per;
		do @(posedge clk); while (!in_ready);
		if (op == FUNC_DECODE)
			decode_sent++;
		else
			encode_sent++;
	endtask

	task automatic decode_item(input logic [20:0] line);
		send_item(FUNC_DECODE, line, $urandom);
	endtask

	task automatic encode_item(input logic [31:0] per);
		send_item(FUNC_ENCODE, 21'($urandom), per);
	endtask

	// A clean line for a packet; the inverted 21-bit line decodes the same.
	function automatic logic [20:0] clean_line(input logic [15:0] pkt, input logic invert);
		logic [20:0] line;
		line = {1'b0, line_of_packet(pkt)};
		return invert ? ~line : line;
	endfunction

	task automatic random_items(input int count);
		logic [15:0] pkt;
		logic [20:0] line;
		logic [31:0] per;
		int kind;
		int k;
		for (k = 0; k < count; k++) begin
			kind = $urandom_range(0, 99);
			pkt = 16'($urandom);
			if ($urandom_range(0, 1))
				pkt[3:0] = packet_crc(pkt[15:4]);
			line = clean_line(pkt, 1'($urandom_range(0, 1)));
			if (kind < 30) begin
				decode_item(line);
			end else if (kind < 45) begin
				line[$urandom_range(0, 20)] ^= 1'b1;
				decode_item(line);
			end else if (kind < 55) begin
				decode_item(21'($urandom));
			end else if (kind < 75) begin
				encode_item($urandom >> $urandom_range(0, 31));
			end else if (kind < 88) begin
				// Near an exponent step or the saturation boundary.
				per = (32'd1 << $urandom_range(9, 16)) + $urandom_range(0, 4) - 2;
				encode_item(per);
			end else begin
				encode_item($urandom);
			end
		end
	endtask

	initial begin
		logic [20:0] broken;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_DECODE;
		rx_frame <= '0;
		period_us <= '0;
		out_ready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling on either side.
		decode_item(21'h000000);
		decode_item(21'h1FFFFF);
		decode_item(clean_line(16'h0000, 1'b0));
		decode_item(clean_line(16'h0000, 1'b1));
		decode_item(clean_line(16'hFFFF, 1'b0));
		decode_item(clean_line({3'd7, 9'd511, packet_crc({3'd7, 9'd511})}, 1'b1));
		decode_item(clean_line({3'd0, 9'd1, packet_crc({3'd0, 9'd1})}, 1'b0));
		broken = clean_line(16'h1234, 1'b0);
		broken[0] ^= 1'b1;
		decode_item(broken);
		encode_item(32'd0);
		encode_item(32'd1);
		encode_item(32'd511);
		encode_item(32'd512);
		encode_item(32'd513);
		encode_item(32'd1023);
		encode_item(32'd1024);
		encode_item(32'd65535);
		encode_item(32'd65536);
		encode_item(32'd65537);
		encode_item(32'h8000_0000);
		encode_item(32'hFFFF_FFFF);

		random_items(170);
		send_idle_pct = 73;
		random_items(160);
		send_idle_pct = 0;
		stall_pct = 73;
		random_items(160);
		send_idle_pct = 26;
		stall_pct = 26;
		random_items(160);

		in_valid <= 1'b0;
		do @(posedge clk); while (awaited != 0);
		repeat (10) @(posedge clk);

		$display("Covered %0d decodes (clean, corrupted and noise lines) and %0d encodes",
			decode_sent, encode_sent);
		$display("under four idle/stall mixes; %0d results checked, %0d with a failing CRC.",
			checked, crc_bad);
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
